/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

/* hw/rtl/plv_pkg.sv */
// Shared types and constants of the polygon list validator.
`timescale 1ns / 1ps

package plv_pkg;

   // Width of the saturating word position counter.
   localparam int POSITION_BITS = 16;

   // Field widths
   localparam int WORD_BITS     = 32;
   localparam int MATERIAL_BITS = 16;
   localparam int VERDICT_BITS  = 3;
   localparam int FPOS_BITS     = 16;

   // Smallest legal vertex count of a polygon
   localparam logic [WORD_BITS-1:0] MIN_POLYGON_SIZE = 32'd3;

   // Verdict codes
   localparam logic [VERDICT_BITS-1:0] V_OK        = 3'd0;
   localparam logic [VERDICT_BITS-1:0] V_EARLY_END = 3'd1;
   localparam logic [VERDICT_BITS-1:0] V_TOO_SMALL = 3'd2;
   localparam logic [VERDICT_BITS-1:0] V_MATERIAL  = 3'd3;
   localparam logic [VERDICT_BITS-1:0] V_VERTEX    = 3'd4;
   localparam logic [VERDICT_BITS-1:0] V_NO_END    = 3'd5;

   // Configuration register indexes
   localparam logic CSR_MATERIAL_COUNT = 1'b0;
   localparam logic CSR_VERTEX_LIMIT   = 1'b1;

   // One result beat
   typedef struct packed {
      logic [WORD_BITS-1:0]    fault_value;
      logic [FPOS_BITS-1:0]    fault_position;
      logic [VERDICT_BITS-1:0] verdict;
   } result_type;

endpackage

/* hw/rtl/polygon_list_validator.sv */
// Polygon list validator: checks a stream of list words and gives one verdict per list.
`timescale 1ns / 1ps

// Channel  Direction  Beat contents
// req      in         tdata[31:0] word; tlast last_word
// rsp      out        tdata[15:0] fault_position, [47:16] fault_value; tuser verdict
// csr      in         write only: csr_addr 0 material_count, 1 vertex_count_limit
//
// One word per cycle while the result register is free or rsp_tready is high: a word is
// held in the input register, checked against the list state by compares and a counter
// update, and its verdict, if any, lands in the result register.
// Reset clears the list state, the configuration registers and both valid flags.
// A stalled rsp holds the result register and the word in the input register;
// req_tready drops while both registers are full and rsp_tready is low.

module polygon_list_validator (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] word
   input  logic        req_tlast,   // last_word
   // verdicts
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] fault_position, [47:16] fault_value
   output logic [2:0]  rsp_tuser,   // [2:0] verdict
   // configuration
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int PB = plv_pkg::POSITION_BITS;
   localparam int WB = plv_pkg::WORD_BITS;

   // Parse phase codes
   localparam logic [1:0] PH_COUNT    = 2'd0;
   localparam logic [1:0] PH_MATERIAL = 2'd1;
   localparam logic [1:0] PH_VERTEX   = 2'd2;

   localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

   // Configuration registers
   logic [plv_pkg::MATERIAL_BITS-1:0] material_count_ff;
   logic [WB-1:0]                     vertex_limit_ff;

   // Input register
   logic          in_valid_ff, in_valid_in;
   logic [WB-1:0] in_word_ff;
   logic          in_last_ff;

   // List state
   logic [1:0]    phase_ff, phase_in;
   logic [WB-1:0] left_ff, left_in;
   logic [PB-1:0] pos_ff, pos_in;
   logic          swallow_ff, swallow_in;

   // Result register
   logic                 out_valid_ff, out_valid_in;
   plv_pkg::result_type  out_ff;

   logic                 proc_fire;
   logic                 have;
   logic [2:0]           verdict;
   logic [WB-1:0]        left_dec;

   // Check stage advances when the result register is free or being emptied
   assign proc_fire  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_fire;
   assign left_dec   = left_ff - 32'd1;

   // Check the held word against the list state
   always_comb begin
      have       = 1'b0;
      verdict    = plv_pkg::V_OK;
      phase_in   = phase_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      swallow_in = swallow_ff;
      if (!swallow_ff) begin
         unique case (phase_ff)
            PH_MATERIAL: begin
               if (in_word_ff >= WB'(material_count_ff)) begin
                  verdict = plv_pkg::V_MATERIAL;
                  have    = 1'b1;
               end else begin
                  phase_in = PH_VERTEX;
               end
            end
            PH_VERTEX: begin
               if (in_word_ff >= vertex_limit_ff) begin
                  verdict = plv_pkg::V_VERTEX;
                  have    = 1'b1;
               end else begin
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     phase_in = PH_COUNT;
                  end
               end
            end
            default: begin
               if (in_word_ff == '0) begin
                  verdict = in_last_ff ? plv_pkg::V_OK : plv_pkg::V_EARLY_END;
                  have    = 1'b1;
               end else if (in_word_ff < plv_pkg::MIN_POLYGON_SIZE) begin
                  verdict = plv_pkg::V_TOO_SMALL;
                  have    = 1'b1;
               end else begin
                  left_in  = in_word_ff;
                  phase_in = PH_MATERIAL;
               end
            end
         endcase
         if (!have && in_last_ff) begin
            verdict = plv_pkg::V_NO_END;
            have    = 1'b1;
         end
      end
      // Last word starts a fresh list; otherwise advance the saturating position
      if (in_last_ff) begin
         phase_in   = PH_COUNT;
         left_in    = '0;
         pos_in     = '0;
         swallow_in = 1'b0;
      end else begin
         if (have) begin
            swallow_in = 1'b1;
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = proc_fire ? have : (out_valid_ff && !rsp_tready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         phase_ff          <= PH_COUNT;
         left_ff           <= '0;
         pos_ff            <= '0;
         swallow_ff        <= 1'b0;
         material_count_ff <= '0;
         vertex_limit_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (proc_fire) begin
            phase_ff   <= phase_in;
            left_ff    <= left_in;
            pos_ff     <= pos_in;
            swallow_ff <= swallow_in;
         end
         if (csr_we) begin
            unique case (csr_addr)
               plv_pkg::CSR_MATERIAL_COUNT: begin
                  material_count_ff <= csr_wdata[plv_pkg::MATERIAL_BITS-1:0];
               end
               plv_pkg::CSR_VERTEX_LIMIT: begin
                  vertex_limit_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_word_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (proc_fire && have) begin
         out_ff.verdict        <= verdict;
         out_ff.fault_position <= plv_pkg::FPOS_BITS'(pos_ff);
         out_ff.fault_value    <= in_word_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.verdict;
   assign rsp_tdata  = {out_ff.fault_value, out_ff.fault_position};

endmodule

/* hw/rtl/plv_checker.sv */
// Port-level checker for the polygon list validator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   logic [31:0] rsp_value;
   logic        is_ok;
   logic        is_small;

   // Split out the fault value and the verdict kinds under check
   assign rsp_value = rsp_tdata[47:16];
   assign is_ok     = rsp_tvalid && (rsp_tuser == plv_pkg::V_OK);
   assign is_small  = rsp_tvalid && (rsp_tuser == plv_pkg::V_TOO_SMALL);

   // No verdict directly after reset
   `ASSERT_ALWAYS(a_idle_after_reset, clock, reset, $past(reset) |-> !rsp_tvalid)

   // A stalled verdict stays offered
   `ASSERT_ALWAYS(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)

   // Only defined verdict codes appear
   `ASSERT_ALWAYS(a_code_range, clock, reset, rsp_tvalid |-> (rsp_tuser <= plv_pkg::V_NO_END))

   // An ok list ends on a zero word
   `ASSERT_ALWAYS(a_ok_zero, clock, reset, is_ok |-> (rsp_value == 32'd0))

   // A too small polygon has a count of one or two
   `ASSERT_ALWAYS(a_small_val, clock, reset, is_small |-> (rsp_value == 32'd1 || rsp_value == 32'd2))

endmodule

bind polygon_list_validator plv_checker u_plv_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench of the polygon list validator: random lists against a verdict predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int WATCHDOG_CYCLES = 1000;
   localparam int DRAIN_CYCLES    = 8;

   typedef logic [plv_pkg::WORD_BITS-1:0] word_type;

   typedef struct packed {
      word_type word;
      logic     last;
   } list_beat_type;

   typedef enum logic [1:0] {
      WANT_COUNT    = 2'd0,
      WANT_MATERIAL = 2'd1,
      WANT_VERTEX   = 2'd2
   } list_phase_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic        csr_addr   = 1'b0;
   logic [31:0] csr_wdata  = '0;

   polygon_list_validator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Words waiting for the driver, verdicts waiting for the block
   list_beat_type       pending_words[$];
   plv_pkg::result_type expected_verdicts[$];
   int                  words_queued = 0;
   int                  words_taken  = 0;
   int                  fail_count   = 0;
   logic                req_taken    = 1'b0;

   // Predictor copy of the configuration and the list state
   logic [plv_pkg::MATERIAL_BITS-1:0] model_materials;
   word_type                          model_vertex_limit;
   list_phase_type                    model_phase;
   word_type                          model_vertices_left;
   logic [plv_pkg::POSITION_BITS-1:0] model_position;
   logic                              model_swallow;

   // Generator view of the configuration in force
   word_type gen_materials;
   word_type gen_vertex_limit;

   // Burst counters keep stretches free of idling
   int req_calm  = 0;
   int rsp_calm  = 0;
   int gap_left  = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   // Pause length: mostly none or short, a few long
   function automatic int pick_pause(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 2) begin
         calm = $urandom_range(80, 30);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Advance the list state by one word; return 1 when a verdict is due
   function automatic bit judge_word(input word_type w, input logic last,
                                     output plv_pkg::result_type v);
      bit                               have;
      logic [plv_pkg::VERDICT_BITS-1:0] code;
      have = 1'b0;
      code = plv_pkg::V_OK;
      if (!model_swallow) begin
         case (model_phase)
            WANT_MATERIAL: begin
               if (w >= {16'd0, model_materials}) begin
                  code = plv_pkg::V_MATERIAL;
                  have = 1'b1;
               end else begin
                  model_phase = WANT_VERTEX;
               end
            end
            WANT_VERTEX: begin
               if (w >= model_vertex_limit) begin
                  code = plv_pkg::V_VERTEX;
                  have = 1'b1;
               end else begin
                  model_vertices_left = model_vertices_left - 32'd1;
                  if (model_vertices_left == '0) model_phase = WANT_COUNT;
               end
            end
            default: begin
               // zero count: terminator, legal only on the final word
               if (w == '0) begin
                  code = last ? plv_pkg::V_OK : plv_pkg::V_EARLY_END;
                  have = 1'b1;
               end else if (w < plv_pkg::MIN_POLYGON_SIZE) begin
                  code = plv_pkg::V_TOO_SMALL;
                  have = 1'b1;
               end else begin
                  model_vertices_left = w;
                  model_phase = WANT_MATERIAL;
               end
            end
         endcase
         if (!have && last) begin
            code = plv_pkg::V_NO_END;
            have = 1'b1;
         end
      end
      v.verdict        = code;
      v.fault_position = plv_pkg::FPOS_BITS'(model_position);
      v.fault_value    = w;
      // The final word starts a fresh list; otherwise the position saturates
      if (last) begin
         model_phase         = WANT_COUNT;
         model_vertices_left = '0;
         model_position      = '0;
         model_swallow       = 1'b0;
      end else begin
         if (have) model_swallow = 1'b1;
         if (model_position != '1) model_position = model_position + 1'b1;
      end
      return have;
   endfunction

   // Monitor: track config writes, check rsp beats, predict on req beats
   always @(posedge clock) begin
      plv_pkg::result_type got;
      plv_pkg::result_type want;
      plv_pkg::result_type next_verdict;
      req_taken <= !reset && req_tvalid && req_tready;
      if (reset) begin
         model_materials     = '0;
         model_vertex_limit  = '0;
         model_phase         = WANT_COUNT;
         model_vertices_left = '0;
         model_position      = '0;
         model_swallow       = 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_addr == plv_pkg::CSR_MATERIAL_COUNT)
               model_materials = csr_wdata[plv_pkg::MATERIAL_BITS-1:0];
            else
               model_vertex_limit = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.verdict        = rsp_tuser;
            got.fault_position = rsp_tdata[15:0];
            got.fault_value    = rsp_tdata[47:16];
            if (expected_verdicts.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected verdict: expected none, got %0d pos %0d value %h",
                        $time, got.verdict, got.fault_position, got.fault_value);
            end else begin
               want = expected_verdicts.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: verdict mismatch: expected %0d pos %0d value %h, %s",
                           $time, want.verdict, want.fault_position, want.fault_value,
                           $sformatf("got %0d pos %0d value %h",
                                     got.verdict, got.fault_position, got.fault_value));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            words_taken++;
            if (judge_word(req_tdata, req_tlast, next_verdict))
               expected_verdicts.push_back(next_verdict);
         end
      end
   end

   // Driver: hold a beat until taken, then idle a while or send the next word
   always @(negedge clock) begin
      list_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left--;
         end else if (pending_words.size() > 0) begin
            beat = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= beat.word;
            req_tlast  <= beat.last;
            gap_left   = pick_pause(req_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(99) < 25) stall_left = pick_pause(rsp_calm);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_word(input word_type w, input logic last);
      list_beat_type beat;
      beat.word = w;
      beat.last = last;
      pending_words.push_back(beat);
      words_queued++;
   endtask

   // Queue a list, marking only its final word as last
   task automatic push_list(input word_type lst[$]);
      foreach (lst[i]) push_word(lst[i], i == lst.size() - 1);
   endtask

   // Wait until every word is taken and every verdict is in, then let the pipe settle
   task automatic wait_drained();
      while (words_taken != words_queued || expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic addr, input word_type data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_limits(input logic [plv_pkg::MATERIAL_BITS-1:0] materials,
                             input word_type vlimit);
      write_csr(plv_pkg::CSR_MATERIAL_COUNT, {16'd0, materials});
      write_csr(plv_pkg::CSR_VERTEX_LIMIT, vlimit);
      gen_materials    = {16'd0, materials};
      gen_vertex_limit = vlimit;
   endtask

   function automatic word_type pick_below(input word_type bound);
      int r;
      r = $urandom_range(3);
      if (bound == '0) return $urandom;
      if (r == 0) return '0;
      if (r == 1) return bound - 32'd1;
      return $urandom_range(bound - 32'd1, 0);
   endfunction

   function automatic word_type pick_at_or_above(input word_type bound);
      int r;
      r = $urandom_range(3);
      if (r == 0) return bound;
      if (r == 1) return '1;
      return bound + $urandom_range(~bound, 0);
   endfunction

   // Mostly well-formed lists, some with one injected fault, the rest noise
   task automatic build_random_list();
      word_type lst[$];
      int       kind;
      int       records;
      int       count;
      int       spot;
      kind = $urandom_range(99);
      if (kind < 75) begin
         records = $urandom_range(3, 0);
         repeat (records) begin
            count = ($urandom_range(99) < 85) ? $urandom_range(6, 3) : $urandom_range(20, 7);
            lst.push_back(word_type'(count));
            lst.push_back(pick_below(gen_materials));
            repeat (count) lst.push_back(pick_below(gen_vertex_limit));
         end
         lst.push_back('0);
         if ($urandom_range(99) < 40) begin
            spot = $urandom_range(lst.size() - 1, 0);
            case ($urandom_range(6))
               0: lst[spot] = $urandom;
               1: lst[spot] = '0;
               2: while (lst.size() > spot + 1) void'(lst.pop_back());
               3: lst[lst.size() - 1] = $urandom_range(40, 1);
               4: lst[spot] = $urandom_range(2, 1);
               5: lst[spot] = pick_at_or_above(gen_vertex_limit);
               default: lst[spot] = pick_at_or_above(gen_materials);
            endcase
         end
      end else begin
         repeat ($urandom_range(8, 1))
            lst.push_back(($urandom_range(1) == 0) ? word_type'($urandom_range(5, 0))
                                                   : word_type'($urandom));
      end
      push_list(lst);
   endtask

   task automatic run_phase(input logic [plv_pkg::MATERIAL_BITS-1:0] materials,
                            input word_type vlimit, input int n_words);
      int start;
      wait_drained();
      set_limits(materials, vlimit);
      start = words_queued;
      while (words_queued - start < n_words) build_random_list();
   endtask

   // Stimulus sequence
   initial begin
      word_type lst[$];
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lists: every verdict, bounds and faults on the final word
      set_limits(16'd4, 32'd10);
      lst = '{32'd0};                                 push_list(lst);
      lst = '{32'd3, 32'd3, 32'd0, 32'd9, 32'd9, 32'd0}; push_list(lst);
      lst = '{32'd0, 32'd7};                          push_list(lst);
      lst = '{32'd2, 32'd1};                          push_list(lst);
      lst = '{32'd3, 32'hFFFF_FFFF, 32'd0};           push_list(lst);
      lst = '{32'd4, 32'd0, 32'd1, 32'd10, 32'd5};    push_list(lst);
      lst = '{32'd3, 32'd0, 32'd1, 32'd2, 32'd5};     push_list(lst);
      lst = '{32'd1};                                 push_list(lst);

      // Random lists under several configurations, extremes included
      run_phase(16'd0, 32'd0, 60);
      run_phase(16'hFFFF, 32'hFFFF_FFFF, 130);
      run_phase(16'd1, 32'd1, 120);
      run_phase(16'($urandom_range(20, 1)), word_type'($urandom_range(50, 1)), 130);
      run_phase(16'($urandom_range(16'hFFFF, 0)), word_type'($urandom), 130);
      run_phase(16'd3, 32'd5, 100);

      wait_drained();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/plv_pkg.sv
hw/rtl/polygon_list_validator.sv
hw/rtl/plv_checker.sv
dv/tb_top.sv
